[hw/rtl/rdf_pkg.sv]
// Package: shared widths, word types, character codes and digit mapping.
`timescale 1ns / 1ps

package rdf_pkg;

  localparam int INT_BITS        = 32;
  localparam int FRAC_BITS       = 32;
  localparam int MAX_FRAC_DIGITS = 30;

  localparam int IN_INT_W   = 32;
  localparam int IN_FRAC_W  = 32;
  localparam int RADIX_W    = 6;
  localparam int FRAC_CFG_W = 5;
  localparam int CHAR_W     = 7;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 6;
  localparam logic [CFG_INDEX_W-1:0] CFG_RADIX       = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAC_DIGITS = CFG_INDEX_W'(1);

  localparam logic [RADIX_W-1:0]    RADIX_RESET       = RADIX_W'(10);
  localparam logic [FRAC_CFG_W-1:0] FRAC_DIGITS_RESET = FRAC_CFG_W'(4);
  localparam logic [RADIX_W-1:0]    RADIX_MIN         = RADIX_W'(2);
  localparam logic [RADIX_W-1:0]    RADIX_MAX         = RADIX_W'(36);

  // integer divider retires this many dividend bits per cycle
  localparam int DIV_CHUNK  = 8;
  localparam int DIV_STEPS  = (INT_BITS + DIV_CHUNK - 1) / DIV_CHUNK;
  localparam int INT_PAD_W  = DIV_STEPS * DIV_CHUNK;
  localparam int CHUNK_CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam int DIGIT_CNT_W = $clog2(INT_BITS + 1);
  localparam int DIGIT_IDX_W = $clog2(INT_BITS);
  localparam int FRAC_LEFT_W = $clog2(MAX_FRAC_DIGITS + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CH_MINUS      = CHAR_W'(45);
  localparam logic [CHAR_W-1:0] CH_DOT        = CHAR_W'(46);
  localparam logic [CHAR_W-1:0] CH_ZERO       = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CH_ALPHA_BASE = CHAR_W'(55);
  localparam logic [RADIX_W-1:0] DIGIT_MAX_DEC = RADIX_W'(9);
  localparam logic [RADIX_W-1:0] DIGIT_MAX_ALL = RADIX_W'(35);

  typedef struct packed {
    logic                 negative;
    logic [IN_INT_W-1:0]  int_part;
    logic [IN_FRAC_W-1:0] frac_part;
  } in_word_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
  } out_word_t;

  typedef struct packed {
    logic      valid;
    out_word_t word;
  } push_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } queue_status_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] ch;
    if (d <= DIGIT_MAX_DEC) begin
      ch = CH_ZERO + CHAR_W'(d);
    end else if (d <= DIGIT_MAX_ALL) begin
      ch = CH_ALPHA_BASE + CHAR_W'(d);
    end else begin
      ch = '0;
    end
    return ch;
  endfunction

endpackage

[hw/rtl/rdf_queue.sv]
// Character queue between the conversion front end and the output port.
`timescale 1ns / 1ps

module rdf_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  rdf_pkg::push_t         push,
  output rdf_pkg::queue_status_t status,
  output logic                   out_valid,
  input  logic                   out_stall,
  output rdf_pkg::out_word_t     out_data
);

  rdf_pkg::out_word_t             mem [rdf_pkg::QUEUE_DEPTH];
  logic [rdf_pkg::QPTR_W-1:0]     wr_ptr, wr_ptr_next;
  logic [rdf_pkg::QPTR_W-1:0]     rd_ptr, rd_ptr_next;
  logic [rdf_pkg::QCNT_W-1:0]     count, count_next;
  logic                           do_push, do_pop;

  assign status.full  = (count == rdf_pkg::QCNT_W'(rdf_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign status.count = count;

  assign do_push = push.valid && !status.full;
  assign do_pop  = out_valid && !out_stall;

  assign out_valid = !status.empty;
  assign out_data  = mem[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (do_push) begin
      wr_ptr_next = (wr_ptr == rdf_pkg::QPTR_W'(rdf_pkg::QUEUE_DEPTH - 1)) ? '0
                    : wr_ptr + rdf_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_next = (rd_ptr == rdf_pkg::QPTR_W'(rdf_pkg::QUEUE_DEPTH - 1)) ? '0
                    : rd_ptr + rdf_pkg::QPTR_W'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   count_next = count + rdf_pkg::QCNT_W'(1);
      2'b01:   count_next = count - rdf_pkg::QCNT_W'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.word;
    end
  end

endmodule

[hw/rtl/rdf_front.sv]
// Front end: takes a number, divides out integer digits, generates the characters.
`timescale 1ns / 1ps

module rdf_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  rdf_pkg::in_word_t               in_data,
  input  logic [rdf_pkg::RADIX_W-1:0]     radix,
  input  logic [rdf_pkg::FRAC_CFG_W-1:0]  frac_digits,
  input  rdf_pkg::queue_status_t          q_status,
  output rdf_pkg::push_t                  push
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SIGN = 6'b000010,
    S_DIV  = 6'b000100,
    S_INT  = 6'b001000,
    S_DOT  = 6'b010000,
    S_FRAC = 6'b100000
  } state_t;

  localparam int PROD_W = rdf_pkg::FRAC_BITS + rdf_pkg::RADIX_W;

  state_t                              state, state_next;
  logic [rdf_pkg::DIGIT_CNT_W-1:0]     digit_count, digit_count_next;
  logic [rdf_pkg::CHUNK_CNT_W-1:0]     chunk_cnt, chunk_cnt_next;
  logic [rdf_pkg::FRAC_LEFT_W-1:0]     frac_left, frac_left_next;

  logic [rdf_pkg::INT_PAD_W-1:0]       int_work, int_work_next;
  logic [rdf_pkg::FRAC_BITS-1:0]       frac_work, frac_work_next;
  logic [rdf_pkg::RADIX_W-1:0]         rem, rem_next;
  logic [rdf_pkg::RADIX_W-1:0]         radix_work, radix_work_next;
  logic [rdf_pkg::FRAC_LEFT_W-1:0]     nf_work, nf_work_next;
  logic                                store_we;
  logic [rdf_pkg::RADIX_W-1:0]         digit_store [rdf_pkg::INT_BITS];

  logic                                accept;
  logic [rdf_pkg::RADIX_W-1:0]         radix_clamped;
  logic [rdf_pkg::FRAC_LEFT_W-1:0]     nf_clamped;
  logic [rdf_pkg::DIV_CHUNK-1:0]       top_bits, qbits;
  logic [rdf_pkg::RADIX_W:0]           rem_t;
  logic [rdf_pkg::RADIX_W-1:0]         div_rem;
  logic [rdf_pkg::INT_PAD_W-1:0]       quotient_shift;
  logic [rdf_pkg::DIGIT_CNT_W-1:0]     digit_last;
  logic [rdf_pkg::RADIX_W-1:0]         int_digit;
  logic [PROD_W-1:0]                   prod;
  logic [rdf_pkg::RADIX_W-1:0]         frac_digit;

  assign in_stall = rst || (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (radix < rdf_pkg::RADIX_MIN) begin
      radix_clamped = rdf_pkg::RADIX_MIN;
    end else if (radix > rdf_pkg::RADIX_MAX) begin
      radix_clamped = rdf_pkg::RADIX_MAX;
    end else begin
      radix_clamped = radix;
    end
    if (frac_digits > rdf_pkg::FRAC_CFG_W'(rdf_pkg::MAX_FRAC_DIGITS)) begin
      nf_clamped = rdf_pkg::FRAC_LEFT_W'(rdf_pkg::MAX_FRAC_DIGITS);
    end else begin
      nf_clamped = rdf_pkg::FRAC_LEFT_W'(frac_digits);
    end
  end

  // one chunk of restoring division by the radix; the remainder stays below 64
  assign top_bits = int_work[rdf_pkg::INT_PAD_W-1 -: rdf_pkg::DIV_CHUNK];

  always_comb begin
    rem_t = {1'b0, rem};
    qbits = '0;
    for (int k = 0; k < rdf_pkg::DIV_CHUNK; k++) begin
      rem_t = {rem_t[rdf_pkg::RADIX_W-1:0], top_bits[rdf_pkg::DIV_CHUNK-1-k]};
      if (rem_t >= {1'b0, radix_work}) begin
        rem_t = rem_t - {1'b0, radix_work};
        qbits[rdf_pkg::DIV_CHUNK-1-k] = 1'b1;
      end
    end
  end

  assign div_rem        = rem_t[rdf_pkg::RADIX_W-1:0];
  assign quotient_shift = rdf_pkg::INT_PAD_W'({int_work, qbits});

  assign digit_last = digit_count - rdf_pkg::DIGIT_CNT_W'(1);
  assign int_digit  = digit_store[digit_last[rdf_pkg::DIGIT_IDX_W-1:0]];

  assign prod = {{rdf_pkg::RADIX_W{1'b0}}, frac_work}
              * {{rdf_pkg::FRAC_BITS{1'b0}}, radix_work};
  assign frac_digit = prod[rdf_pkg::FRAC_BITS +: rdf_pkg::RADIX_W];

  always_comb begin
    state_next       = state;
    digit_count_next = digit_count;
    chunk_cnt_next   = chunk_cnt;
    frac_left_next   = frac_left;
    int_work_next    = int_work;
    frac_work_next   = frac_work;
    rem_next         = rem;
    radix_work_next  = radix_work;
    nf_work_next     = nf_work;
    store_we         = 1'b0;
    push.valid       = 1'b0;
    push.word        = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          int_work_next    = rdf_pkg::INT_PAD_W'(in_data.int_part[rdf_pkg::INT_BITS-1:0]);
          frac_work_next   = in_data.frac_part[rdf_pkg::FRAC_BITS-1:0];
          radix_work_next  = radix_clamped;
          nf_work_next     = nf_clamped;
          rem_next         = '0;
          chunk_cnt_next   = '0;
          digit_count_next = '0;
          state_next       = in_data.negative ? S_SIGN : S_DIV;
        end
      end
      S_SIGN: begin
        push.word.char_code = rdf_pkg::CH_MINUS;
        push.valid          = !q_status.full;
        if (!q_status.full) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        int_work_next = quotient_shift;
        rem_next      = div_rem;
        if (chunk_cnt == rdf_pkg::CHUNK_CNT_W'(rdf_pkg::DIV_STEPS - 1)) begin
          store_we         = 1'b1;
          rem_next         = '0;
          chunk_cnt_next   = '0;
          digit_count_next = digit_count + rdf_pkg::DIGIT_CNT_W'(1);
          if (quotient_shift == '0 ||
              digit_count_next == rdf_pkg::DIGIT_CNT_W'(rdf_pkg::INT_BITS)) begin
            state_next = S_INT;
          end
        end else begin
          chunk_cnt_next = chunk_cnt + rdf_pkg::CHUNK_CNT_W'(1);
        end
      end
      S_INT: begin
        // digits were stored least significant first; read them back downward
        push.word.char_code = rdf_pkg::digit_to_ascii(int_digit);
        push.valid          = !q_status.full;
        if (!q_status.full) begin
          digit_count_next = digit_last;
          if (digit_last == '0) begin
            state_next = S_DOT;
          end
        end
      end
      S_DOT: begin
        push.word.char_code = rdf_pkg::CH_DOT;
        push.word.last      = (nf_work == '0);
        push.valid          = !q_status.full;
        if (!q_status.full) begin
          frac_left_next = nf_work;
          state_next     = (nf_work == '0) ? S_IDLE : S_FRAC;
        end
      end
      S_FRAC: begin
        push.word.char_code = rdf_pkg::digit_to_ascii(frac_digit);
        push.word.last      = (frac_left == rdf_pkg::FRAC_LEFT_W'(1));
        push.valid          = !q_status.full;
        if (!q_status.full) begin
          frac_work_next = prod[rdf_pkg::FRAC_BITS-1:0];
          frac_left_next = frac_left - rdf_pkg::FRAC_LEFT_W'(1);
          if (frac_left == rdf_pkg::FRAC_LEFT_W'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      digit_count <= '0;
      chunk_cnt   <= '0;
      frac_left   <= '0;
    end else begin
      state       <= state_next;
      digit_count <= digit_count_next;
      chunk_cnt   <= chunk_cnt_next;
      frac_left   <= frac_left_next;
    end
  end

  always_ff @(posedge clk) begin
    int_work   <= int_work_next;
    frac_work  <= frac_work_next;
    rem        <= rem_next;
    radix_work <= radix_work_next;
    nf_work    <= nf_work_next;
    if (store_we) begin
      digit_store[digit_count[rdf_pkg::DIGIT_IDX_W-1:0]] <= div_rem;
    end
  end

endmodule

[hw/rtl/radix_digit_formatter_top.sv]
// Top level: config registers, conversion front end and character queue.
//
// Usage: a number word (sign flag, integer part, Q0.32 fraction) enters on
// in_valid/in_stall and comes out as a string of ASCII character words on
// out_valid/out_stall: optional '-', integer digits most significant first,
// '.', then frac_digits fraction digits; the final word has last set.
// cfg_valid/cfg_ready writes radix (index 0) and frac_digits (index 1);
// cfg_ready is always high, and the values are sampled when a number is taken.
// Timing: the integer divider retires 8 bits of dividend per cycle. A sign
// character is sent before the division starts; all integer digits are divided
// out before the top one is sent. Each character then enters a 4-word queue, one
// per cycle while the queue is not full. A new number is taken once the last
// character of the previous one is in the queue.
// Reset: synchronous, clears the queue, returns to idle and restores radix 10
// and 4 fraction digits. While out_stall is high the queue fills and the
// front end waits; nothing is lost or reordered.
`timescale 1ns / 1ps

module radix_digit_formatter_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  rdf_pkg::in_word_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output rdf_pkg::out_word_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rdf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [rdf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [rdf_pkg::RADIX_W-1:0]    radix;
  logic [rdf_pkg::FRAC_CFG_W-1:0] frac_digits;
  rdf_pkg::push_t                 push;
  rdf_pkg::queue_status_t         q_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix       <= rdf_pkg::RADIX_RESET;
      frac_digits <= rdf_pkg::FRAC_DIGITS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == rdf_pkg::CFG_RADIX) begin
        radix <= cfg_data[rdf_pkg::RADIX_W-1:0];
      end else if (cfg_index == rdf_pkg::CFG_FRAC_DIGITS) begin
        frac_digits <= cfg_data[rdf_pkg::FRAC_CFG_W-1:0];
      end
    end
  end

  rdf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .radix       (radix),
    .frac_digits (frac_digits),
    .q_status    (q_status),
    .push        (push)
  );

  rdf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .status    (q_status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // a taken number keeps the front end busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("front end ready right after taking a number");

  // the front end never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push.valid && q_status.full))
    else $error("character pushed into full queue");

  // an idle front end produces no characters
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !push.valid)
    else $error("character pushed while idle");

endmodule

[sim/rdf_checker.sv]
// Checker: watches the number, character and register channels, predicts the text and compares.
`timescale 1ns / 1ps

module rdf_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  rdf_pkg::in_word_t               in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  rdf_pkg::out_word_t              out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [rdf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rdf_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              fail_count,
  output int                              pending,
  output int                              chars_checked
);

  localparam logic [rdf_pkg::CHAR_W-1:0] MINUS_CHAR  = 7'd45;
  localparam logic [rdf_pkg::CHAR_W-1:0] POINT_CHAR  = 7'd46;
  localparam logic [rdf_pkg::CHAR_W-1:0] DIGIT_BASE  = 7'd48;
  localparam logic [rdf_pkg::CHAR_W-1:0] LETTER_BASE = 7'd55;
  localparam logic [rdf_pkg::RADIX_W-1:0]    BOOT_RADIX  = 6'd10;
  localparam logic [rdf_pkg::FRAC_CFG_W-1:0] BOOT_PLACES = 5'd4;
  localparam int unsigned BASE_LO    = 2;
  localparam int unsigned BASE_HI    = 36;
  localparam int unsigned PLACES_CAP = 30;
  localparam int REPORT_LIMIT = 10;

  logic [rdf_pkg::RADIX_W-1:0]    radix_reg;
  logic [rdf_pkg::FRAC_CFG_W-1:0] places_reg;
  rdf_pkg::out_word_t             expected_chars[$];
  rdf_pkg::out_word_t             want;
  int                             errors;
  int                             chars;

  initial begin
    fail_count    = 0;
    pending       = 0;
    chars_checked = 0;
    errors        = 0;
    chars         = 0;
    radix_reg     = BOOT_RADIX;
    places_reg    = BOOT_PLACES;
  end

  function automatic logic [rdf_pkg::CHAR_W-1:0] glyph(input int unsigned v);
    if (v < 10) begin
      return DIGIT_BASE + rdf_pkg::CHAR_W'(v);
    end
    return LETTER_BASE + rdf_pkg::CHAR_W'(v);
  endfunction

  function automatic void add_char(input logic [rdf_pkg::CHAR_W-1:0] ch);
    rdf_pkg::out_word_t c;
    c.char_code = ch;
    c.last      = 1'b0;
    expected_chars.push_back(c);
  endfunction

  // expected text of one number under the current register values
  task automatic format_number(input rdf_pkg::in_word_t w);
    int unsigned        base;
    int unsigned        places;
    int unsigned        nd;
    int unsigned        digits[32];
    logic [31:0]        whole;
    logic [31:0]        frac;
    logic [63:0]        prod;
    rdf_pkg::out_word_t tail;
    base = radix_reg;
    if (base < BASE_LO) base = BASE_LO;
    if (base > BASE_HI) base = BASE_HI;
    places = places_reg;
    if (places > PLACES_CAP) places = PLACES_CAP;
    if (w.negative) add_char(MINUS_CHAR);
    whole = w.int_part;
    nd = 0;
    do begin
      digits[nd] = whole % base;
      whole = whole / base;
      nd++;
    end while (whole != 0);
    for (int i = nd; i > 0; i--) begin
      add_char(glyph(digits[i-1]));
    end
    add_char(POINT_CHAR);
    frac = w.frac_part;
    repeat (places) begin
      prod = 64'(frac) * 64'(base);
      add_char(glyph(prod[63:32]));
      frac = prod[31:0];
    end
    tail = expected_chars.pop_back();
    tail.last = 1'b1;
    expected_chars.push_back(tail);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      radix_reg  = BOOT_RADIX;
      places_reg = BOOT_PLACES;
      expected_chars.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == rdf_pkg::CFG_RADIX) begin
          radix_reg = cfg_data;
        end else if (cfg_index == rdf_pkg::CFG_FRAC_DIGITS) begin
          places_reg = cfg_data[rdf_pkg::FRAC_CFG_W-1:0];
        end
      end
      if (out_valid && !out_stall) begin
        chars++;
        if (expected_chars.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $display("unexpected word %0d: char %h last %b", chars, out_data.char_code,
                     out_data.last);
          end
        end else begin
          want = expected_chars.pop_front();
          if (out_data.char_code !== want.char_code || out_data.last !== want.last) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
              $display("word %0d mismatch: expected char %h last %b, got char %h last %b",
                       chars, want.char_code, want.last, out_data.char_code, out_data.last);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        format_number(in_data);
      end
    end
    fail_count    <= errors;
    pending       <= expected_chars.size();
    chars_checked <= chars;
  end

endmodule

[sim/testbench.sv]
// Testbench top: clock, reset, number and register stimulus, and the final verdict.
`timescale 1ns / 1ps

module testbench;

  localparam int LIMIT        = 400000;
  localparam int IDLE_PCT     = 17;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 17;
  localparam int STEADY_PHASE = 3;
  localparam int PAUSE_PHASE  = 1;
  localparam int TAIL_CYCLES  = 16;
  localparam logic [rdf_pkg::CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [rdf_pkg::CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

  logic                            clk;
  logic                            rst;
  logic                            in_valid;
  logic                            in_stall;
  rdf_pkg::in_word_t               in_data;
  logic                            out_valid;
  logic                            out_stall;
  rdf_pkg::out_word_t              out_data;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [rdf_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [rdf_pkg::CFG_DATA_W-1:0]  cfg_data;

  logic        steady;
  int          cycles;
  int          fail_count;
  int          pending;
  int          chars_checked;
  int          numbers_sent;
  int          settings_used;
  int unsigned digit_base;

  radix_digit_formatter_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rdf_checker chk (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .chars_checked (chars_checked)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    out_stall <= !rst && !steady && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic rdf_pkg::in_word_t number_word(input logic neg,
                                                    input logic [31:0] whole,
                                                    input logic [31:0] frac);
    rdf_pkg::in_word_t w;
    w.negative  = neg;
    w.int_part  = whole;
    w.frac_part = frac;
    return w;
  endfunction

  function automatic rdf_pkg::in_word_t random_number(input int unsigned base);
    rdf_pkg::in_word_t w;
    logic [63:0]       p;
    int unsigned       k;
    w.negative = 1'($urandom_range(1));
    case ($urandom_range(7))
      0: w.int_part = '0;
      1: w.int_part = $urandom_range(base - 1);
      2: begin
        // land on a digit-count boundary: a power of the radix or one below it
        p = 1;
        k = $urandom_range(31, 1);
        while (k > 0 && p * base <= 64'hFFFF_FFFF) begin
          p = p * base;
          k--;
        end
        w.int_part = p[31:0] - $urandom_range(1);
      end
      3: w.int_part = '1;
      4: w.int_part = $urandom >> $urandom_range(31);
      default: w.int_part = $urandom;
    endcase
    case ($urandom_range(5))
      0: w.frac_part = '0;
      1: w.frac_part = '1;
      2: w.frac_part = 32'h8000_0000;
      3: w.frac_part = $urandom >> $urandom_range(31);
      default: w.frac_part = $urandom;
    endcase
    return w;
  endfunction

  task automatic send_number(input rdf_pkg::in_word_t w);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    numbers_sent++;
  endtask

  // hold off new numbers until every expected character has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic configure(input logic [rdf_pkg::CFG_DATA_W-1:0] radix_val,
                           input logic [rdf_pkg::CFG_DATA_W-1:0] places_val,
                           input bit spares);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= rdf_pkg::CFG_RADIX;
    cfg_data  <= radix_val;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= rdf_pkg::CFG_FRAC_DIGITS;
    cfg_data  <= places_val;
    do @(posedge clk); while (!cfg_ready);
    if (spares) begin
      // unused indexes must leave both registers alone
      cfg_index <= CFG_SPARE_LO;
      cfg_data  <= rdf_pkg::CFG_DATA_W'($urandom);
      do @(posedge clk); while (!cfg_ready);
      cfg_index <= CFG_SPARE_HI;
      cfg_data  <= rdf_pkg::CFG_DATA_W'($urandom);
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    digit_base = (radix_val < 2) ? 2 : (radix_val > 36) ? 36 : radix_val;
    settings_used++;
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    steady        = 1'b0;
    cycles        = 0;
    numbers_sent  = 0;
    settings_used = 1;
    digit_base    = 10;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // registers at their reset values
    send_number(number_word(1'b0, 32'd0, 32'd0));
    send_number(number_word(1'b1, '1, '1));
    send_number(number_word(1'b0, 32'd1000000, 32'h8000_0000));

    // radix below two, more fraction digits than the cap
    configure(6'd0, 6'd31, 1'b1);
    send_number(number_word(1'b1, '1, '1));
    send_number(number_word(1'b0, 32'd0, 32'd1));
    send_number(number_word(1'b0, 32'h8000_0000, 32'h5555_5555));

    // radix above thirty-six, no fraction digits: the point ends the text
    configure(6'd63, 6'd0, 1'b0);
    send_number(number_word(1'b0, 32'd35, '1));
    send_number(number_word(1'b1, 32'd36, 32'd0));
    send_number(number_word(1'b0, '1, 32'd0));

    configure(6'd37, 6'd30, 1'b0);
    send_number(number_word(1'b0, 32'd1295, '1));
    send_number(number_word(1'b1, 32'd0, 32'd1));

    // top data bit is dropped for the fraction digit count
    configure(6'd1, 6'b100000, 1'b0);
    send_number(number_word(1'b0, 32'd1, '1));

    configure(6'd36, 6'd1, 1'b0);
    send_number(number_word(1'b0, 32'd1679616, '1));
    send_number(number_word(1'b1, 32'd1679615, 32'h0712_3456));

    configure(6'd16, 6'd8, 1'b0);
    send_number(number_word(1'b0, 32'hDEAD_BEEF, 32'hC0FF_EE00));
    send_number(number_word(1'b1, 32'h0000_00FF, 32'd0));

    configure(6'd2, 6'd30, 1'b0);
    send_number(number_word(1'b0, 32'h8000_0000, 32'hAAAA_AAAA));

    configure(6'd10, 6'd15, 1'b0);
    send_number(number_word(1'b1, 32'h7FFF_FFFF, 32'h1999_999A));

    for (int ph = 0; ph < PHASES; ph++) begin
      configure($urandom_range(1) ? 6'($urandom_range(36, 2)) : 6'($urandom_range(63)),
                6'($urandom_range(63)), 1'b0);
      steady <= (ph == STEADY_PHASE);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == PAUSE_PHASE && k == PHASE_ITEMS / 2) drain();
        send_number(random_number(digit_base));
      end
    end
    steady <= 1'b0;

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Converted %0d numbers into %0d checked characters under %0d register settings,",
             numbers_sent, chars_checked, settings_used);
    $display("including clamped radix values, capped and zero fraction digit counts.");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
